FILE: rtl/snr_and_segmental_snr_meter_top_defines.svh
// assertion macros shared by the snr meter rtl
`ifndef SNR_AND_SEGMENTAL_SNR_METER_TOP_DEFINES_SVH
`define SNR_AND_SEGMENTAL_SNR_METER_TOP_DEFINES_SVH
// implication checked on every clock, skipped during reset
`define SNR_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
// next-cycle implication
`define SNR_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`endif

FILE: rtl/snrm_pkg.sv
// shared types, constants and log table for the snr meter
package snrm_pkg;
   localparam int unsigned DbPerOctaveQ16 = 197283;
   localparam logic [15:0] DefaultFrameLength = 16'd256;
   localparam logic [1:0] ModeOverall = 2'd0;
   localparam logic [1:0] ModeAverage = 2'd1;
   localparam logic [1:0] ModeFrame = 2'd2;
   localparam logic [1:0] ModeUnused = 2'd3;
   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusNoSignal = 2'd1;
   localparam logic [1:0] StatusNoNoise = 2'd2;
   localparam logic RegFrameLength = 1'b0;
   localparam logic RegOutputMode = 1'b1;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b00000001,
      ST_SQ_CLEAN = 8'b00000010,
      ST_SQ_NOISE = 8'b00000100,
      ST_DECIDE = 8'b00001000,
      ST_LOG = 8'b00010000,
      ST_MUL = 8'b00100000,
      ST_DIV = 8'b01000000,
      ST_OUT = 8'b10000000
   } state_type;

   // request to the divider: numerator magnitude and divisor
   typedef struct packed {
      logic start;
      logic [47:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [47:0] quot;
   } div_rsp_type;

   // fractional log2 in q.16 of 1 + (i + 0.5) / 2^bits, squaring method
   function automatic logic [15:0] frac_log2(input int unsigned i, input int unsigned bits);
      logic [63:0] m;
      logic [31:0] r;
      m = ((64'd1 << (bits + 1)) + 64'(2 * i) + 64'd1) << (30 - (bits + 1));
      r = 32'd0;
      for (int k = 0; k < 17; k++) begin
         m = (m * m) >> 30;
         r = r << 1;
         if (m >= (64'd2 << 30)) begin
            r = r | 32'd1;
            m = m >> 1;
         end
      end
      r = (r + 32'd1) >> 1;
      return r[15:0];
   endfunction
endpackage

FILE: rtl/snrm_div.sv
// restoring divider, one quotient bit per cycle
module snrm_div (
   input logic clock,
   input logic reset,
   input snrm_pkg::div_req_type req,
   output snrm_pkg::div_rsp_type rsp
);
   logic [47:0] quot_ff, quot_in;
   logic [48:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [48:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[47:0], quot_ff[47]};
      if (req.start) begin
         quot_in = req.num;
         rem_in = '0;
         den_in = req.den;
         cnt_in = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {17'd0, den_ff}) begin
            rem_in = trial - {17'd0, den_ff};
            quot_in = {quot_ff[46:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
endmodule

FILE: rtl/snr_and_segmental_snr_meter_top.sv
// top level of the snr and segmental snr meter
// Usage: pairs of clean and noisy samples arrive on the req_ stream, tdata
// holding clean_sample in [15:0] and noisy_sample in [31:16]; req_tlast marks
// the final pair of a stream. Results leave on rsp_ with snr_db, status and
// frame_number. csr_ sets the frame size (index 0) and output_mode (index 1);
// the user must write them while the block is idle; the block does not check.
// One shared multiplier squares the clean sample, then the noise; a pair
// with no frame end passes ST_SQ_CLEAN, ST_SQ_NOISE, ST_DECIDE and ST_OUT.
// At a frame end or a mode 0 stream end the two logs are read from the table
// in ST_LOG and the difference is scaled by a constant multiplier in ST_MUL,
// that loads the result in modes 0 and 2; ST_DIV follows a mode 2 stream end.
// The mode 1 average at stream end runs a serial divider.
// The unused mode yields no result. req_tready is low while a pair is
// being worked on and while a result waits. The result register holds its
// value until rsp_tready takes it; a stalled receiver stalls the input.
// Reset is synchronous and active high: it clears all accumulators, sets
// the frame size to 256 and output_mode to 0. The log table is constant logic.
`include "snr_and_segmental_snr_meter_top_defines.svh"
module snr_and_segmental_snr_meter_top #(
   parameter int unsigned SAMPLE_BITS = 16,
   parameter int unsigned LOG_TABLE_BITS = 8
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // clean_sample, noisy_sample
   input logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   input logic req_tlast,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // snr_db [15:0], status [17:16], frame_number [49:18], zero fill
   output logic [55:0] rsp_tdata,
   input logic csr_valid,
   output logic csr_ready,
   input logic csr_index,
   input logic [15:0] csr_data
);
   localparam int unsigned TabDepth = 1 << LOG_TABLE_BITS;
   localparam int unsigned DiffBits = SAMPLE_BITS + 1;

   logic [15:0] log_tab [TabDepth];
   always_comb begin
      for (int i = 0; i < TabDepth; i++)
         log_tab[i] = snrm_pkg::frac_log2(i, LOG_TABLE_BITS);
   end

   snrm_pkg::state_type state_ff, state_in;
   logic [15:0] frame_len_ff;
   logic [1:0] mode_ff;
   logic [63:0] sig_e_ff, sig_e_in, noi_e_ff, noi_e_in;
   logic [15:0] pos_ff, pos_in;
   logic [31:0] frames_ff, frames_in;
   logic signed [47:0] db_sum_ff, db_sum_in;
   logic [1:0] sticky_ff, sticky_in;
   logic signed [SAMPLE_BITS-1:0] clean_ff, noisy_ff;
   logic eos_ff;
   logic [1:0] cmode_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_db_ff, rsp_db_in;
   logic [1:0] rsp_st_ff, rsp_st_in;
   logic [31:0] rsp_fn_ff, rsp_fn_in;
   logic signed [22:0] dlog_ff, dlog_in;
   logic [1:0] est_ff, est_in;
   logic avg_neg_ff, avg_neg_in;

   // shared multiplier: operands chosen by state
   logic [DiffBits-1:0] mag_c, mag_n, mul_a;
   logic [2*DiffBits-1:0] sq;
   logic signed [DiffBits-1:0] diff;
   logic [22:0] dmag;
   logic [40:0] prod;
   logic signed [41:0] pnum;
   logic [17:0] rnd;

   snrm_pkg::div_req_type dreq;
   snrm_pkg::div_rsp_type drsp;
   snrm_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [22:0] log2q(input logic [63:0] v,
                                         input logic [15:0] tab [TabDepth]);
      logic [5:0] e;
      logic [63:0] idx;
      e = '0;
      for (int k = 1; k < 64; k++)
         if (v[k]) e = 6'(k);
      if (e >= 6'(LOG_TABLE_BITS)) idx = v >> (e - 6'(LOG_TABLE_BITS));
      else idx = v << (6'(LOG_TABLE_BITS) - e);
      return {1'b0, e, 16'd0} + {7'd0, tab[idx[LOG_TABLE_BITS-1:0]]};
   endfunction

   assign diff = DiffBits'(noisy_ff) - DiffBits'(clean_ff);
   assign mag_c = clean_ff[SAMPLE_BITS-1] ? -DiffBits'(clean_ff) : DiffBits'(clean_ff);
   assign mag_n = diff[DiffBits-1] ? -diff : diff;
   assign mul_a = (state_ff == snrm_pkg::ST_SQ_CLEAN) ? mag_c : mag_n;
   assign sq = mul_a * mul_a;
   assign dmag = dlog_ff[22] ? -dlog_ff : dlog_ff;
   assign prod = {18'd0, dmag} * 41'(snrm_pkg::DbPerOctaveQ16);
   assign rnd = 18'((prod + 41'd8388608) >> 24);

   logic frame_end;
   logic [15:0] len;
   assign len = (frame_len_ff == 16'd0) ? 16'd1 : frame_len_ff;
   assign frame_end = ({1'b0, pos_ff} + 17'd1) >= {1'b0, len};

   assign req_tready = (state_ff == snrm_pkg::ST_IDLE) && !rsp_valid_ff;
   assign csr_ready = 1'b1;

   logic signed [48:0] sum_w;
   logic [47:0] sum_mag;
   logic signed [16:0] db_v;
   logic [48:0] q_mag;

   always_comb begin
      state_in = state_ff;
      sig_e_in = sig_e_ff;
      noi_e_in = noi_e_ff;
      pos_in = pos_ff;
      frames_in = frames_ff;
      db_sum_in = db_sum_ff;
      sticky_in = sticky_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_db_in = rsp_db_ff;
      rsp_st_in = rsp_st_ff;
      rsp_fn_in = rsp_fn_ff;
      dlog_in = dlog_ff;
      est_in = est_ff;
      avg_neg_in = avg_neg_ff;
      dreq = '0;
      sum_w = '0;
      db_v = '0;
      sum_mag = db_sum_ff[47] ? 48'(-db_sum_ff) : 48'(db_sum_ff);
      q_mag = {1'b0, drsp.quot};
      unique case (state_ff)
         snrm_pkg::ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               state_in = (mode_ff == snrm_pkg::ModeUnused) ? snrm_pkg::ST_OUT
                                                             : snrm_pkg::ST_SQ_CLEAN;
            end
         end
         snrm_pkg::ST_SQ_CLEAN: begin
            sig_e_in = sat_add(sig_e_ff, 64'(sq));
            state_in = snrm_pkg::ST_SQ_NOISE;
         end
         snrm_pkg::ST_SQ_NOISE: begin
            noi_e_in = sat_add(noi_e_ff, 64'(sq));
            state_in = snrm_pkg::ST_DECIDE;
         end
         snrm_pkg::ST_DECIDE: begin
            est_in = (sig_e_ff == 64'd0) ? snrm_pkg::StatusNoSignal :
                     (noi_e_ff == 64'd0) ? snrm_pkg::StatusNoNoise : snrm_pkg::StatusOk;
            if (cmode_ff == snrm_pkg::ModeOverall) begin
               state_in = eos_ff ? snrm_pkg::ST_LOG : snrm_pkg::ST_OUT;
            end else if (frame_end) begin
               state_in = snrm_pkg::ST_LOG;
            end else begin
               pos_in = pos_ff + 16'd1;
               state_in = eos_ff ? snrm_pkg::ST_DIV : snrm_pkg::ST_OUT;
            end
         end
         snrm_pkg::ST_LOG: begin
            dlog_in = $signed(log2q(sig_e_ff, log_tab)) - $signed(log2q(noi_e_ff, log_tab));
            state_in = snrm_pkg::ST_MUL;
         end
         snrm_pkg::ST_MUL: begin
            if (est_ff != snrm_pkg::StatusOk) db_v = '0;
            else if (rnd > 18'd32768 && dlog_ff[22]) db_v = -17'sd32768;
            else if (rnd > 18'd32767 && !dlog_ff[22]) db_v = 17'sd32767;
            else db_v = dlog_ff[22] ? -$signed({1'b0, rnd[15:0]}) : $signed({1'b0, rnd[15:0]});
            state_in = snrm_pkg::ST_OUT;
            if (cmode_ff == snrm_pkg::ModeOverall) begin
               rsp_valid_in = 1'b1;
               rsp_db_in = db_v[15:0];
               rsp_st_in = est_ff;
               rsp_fn_in = '0;
               sig_e_in = '0; noi_e_in = '0; pos_in = '0; frames_in = '0;
               db_sum_in = '0; sticky_in = '0;
            end else begin
               if (cmode_ff == snrm_pkg::ModeFrame) begin
                  rsp_valid_in = 1'b1;
                  rsp_db_in = db_v[15:0];
                  rsp_st_in = est_ff;
                  rsp_fn_in = frames_ff;
               end else if (est_ff != snrm_pkg::StatusOk) begin
                  if (sticky_ff == snrm_pkg::StatusOk) sticky_in = est_ff;
               end else begin
                  sum_w = 49'(db_sum_ff) + 49'(db_v);
                  if (sum_w[48] != sum_w[47])
                     db_sum_in = sum_w[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                  else db_sum_in = sum_w[47:0];
               end
               if (frames_ff != '1) frames_in = frames_ff + 32'd1;
               pos_in = '0; sig_e_in = '0; noi_e_in = '0;
               if (eos_ff) state_in = snrm_pkg::ST_DIV;
            end
         end
         snrm_pkg::ST_DIV: begin
            // mode 1 average, or stream clear in mode 2
            if (cmode_ff == snrm_pkg::ModeAverage && frames_ff != '0 &&
                sticky_ff == snrm_pkg::StatusOk) begin
               if (!drsp.busy && !drsp.done) begin
                  dreq.start = 1'b1;
                  dreq.num = sum_mag + 48'(frames_ff >> 1);
                  dreq.den = frames_ff;
                  avg_neg_in = db_sum_ff[47];
               end else if (drsp.done) begin
                  rsp_valid_in = 1'b1;
                  rsp_st_in = snrm_pkg::StatusOk;
                  rsp_fn_in = frames_ff;
                  if (avg_neg_ff) rsp_db_in = (q_mag > 49'd32768) ? 16'h8000 : 16'(-q_mag);
                  else rsp_db_in = (q_mag > 49'd32767) ? 16'h7FFF : q_mag[15:0];
                  sig_e_in = '0; noi_e_in = '0; pos_in = '0; frames_in = '0;
                  db_sum_in = '0; sticky_in = '0;
                  state_in = snrm_pkg::ST_OUT;
               end
            end else begin
               if (cmode_ff == snrm_pkg::ModeAverage && frames_ff != '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_db_in = '0;
                  rsp_st_in = sticky_ff;
                  rsp_fn_in = frames_ff;
               end
               sig_e_in = '0; noi_e_in = '0; pos_in = '0; frames_in = '0;
               db_sum_in = '0; sticky_in = '0;
               state_in = snrm_pkg::ST_OUT;
            end
         end
         snrm_pkg::ST_OUT: begin
            if (cmode_ff == snrm_pkg::ModeUnused && eos_ff) begin
               sig_e_in = '0; noi_e_in = '0; pos_in = '0; frames_in = '0;
               db_sum_in = '0; sticky_in = '0;
            end
            state_in = snrm_pkg::ST_IDLE;
         end
         default: state_in = snrm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         clean_ff <= req_tdata[SAMPLE_BITS-1:0];
         noisy_ff <= req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
         eos_ff <= req_tlast;
         cmode_ff <= mode_ff;
      end
      rsp_db_ff <= rsp_db_in;
      rsp_st_ff <= rsp_st_in;
      rsp_fn_ff <= rsp_fn_in;
      dlog_ff <= dlog_in;
      est_ff <= est_in;
      avg_neg_ff <= avg_neg_in;
      if (reset) begin
         state_ff <= snrm_pkg::ST_IDLE;
         frame_len_ff <= snrm_pkg::DefaultFrameLength;
         mode_ff <= snrm_pkg::ModeOverall;
         sig_e_ff <= '0;
         noi_e_ff <= '0;
         pos_ff <= '0;
         frames_ff <= '0;
         db_sum_ff <= '0;
         sticky_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sig_e_ff <= sig_e_in;
         noi_e_ff <= noi_e_in;
         pos_ff <= pos_in;
         frames_ff <= frames_in;
         db_sum_ff <= db_sum_in;
         sticky_ff <= sticky_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == snrm_pkg::RegFrameLength) frame_len_ff <= csr_data;
            else if (csr_index == snrm_pkg::RegOutputMode) mode_ff <= csr_data[1:0];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {6'd0, rsp_fn_ff, rsp_st_ff, rsp_db_ff};

   `SNR_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != snrm_pkg::ST_IDLE, !req_tready,
      "input accepted while busy")
   `SNR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result dropped under stall")
   `SNR_ASSERT_IMP(a_div_mode, clock, reset, drsp.busy, state_ff == snrm_pkg::ST_DIV,
      "divider running outside average step")
endmodule
